// File: hw/rtl/assert_macros.svh
// assertion macros shared by the capture block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// File: hw/rtl/lcp_pkg.sv
// types and constants of the logic capture block
`default_nettype none

package lcp_pkg;

    // input opcodes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_HIST      = 3'd0;
    localparam logic [2:0] KIND_TRIG      = 3'd1;
    localparam logic [2:0] KIND_LIVE      = 3'd2;
    localparam logic [2:0] KIND_START_OK  = 3'd3;
    localparam logic [2:0] KIND_START_REF = 3'd4;
    localparam logic [2:0] KIND_STOPPED   = 3'd5;

    // trigger level codes
    localparam logic [1:0] LVL_HIGH = 2'd0;
    localparam logic [1:0] LVL_LOW  = 2'd1;
    localparam logic [1:0] LVL_NONE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ACTIVE_CH  = 3'd0;
    localparam logic [2:0] REG_TRIG_CH    = 3'd1;
    localparam logic [2:0] REG_TRIG_LEVEL = 3'd2;
    localparam logic [2:0] REG_TARGET     = 3'd3;
    localparam logic [2:0] REG_NS_PER     = 3'd4;

    localparam logic [29:0] NS_MAX = 30'd1000000000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one queued job for the back end
    typedef struct packed {
        logic        replay;
        logic [2:0]  kind;
        logic [7:0]  levels;
        logic [63:0] ts;
        logic        done;
    } cmd_t;

    // history store write and clear
    typedef struct packed {
        logic        en;
        logic        clr;
        logic [7:0]  levels;
        logic [63:0] ts;
    } hist_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/lcp_front.sv
// front end: config registers, capture state, sample classification
`default_nettype none
`include "assert_macros.svh"

module lcp_front #(
    parameter int HISTORY_DEPTH = 32,
    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [2:0]       cfg_addr,
    input  wire logic [31:0]      cfg_wr_data,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic [1:0]       s_tuser,
    input  wire logic             q_full,
    output logic                  q_push,
    output lcp_pkg::cmd_t         q_cmd,
    output lcp_pkg::hist_wr_t     hist_wr,
    output logic [AW-1:0]         hist_idx,
    input  wire logic             replay_done
);

    logic [3:0]  active_ch_reg;
    logic [3:0]  trig_ch_reg;
    logic [1:0]  trig_level_reg;
    logic [31:0] target_reg;
    logic [29:0] ns_per_reg;

    logic          running_reg, running_next;
    logic          trig_reg, trig_next;
    logic          pending_reg, pending_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [63:0]   time_reg, time_next;
    logic [31:0]   total_reg, total_next;

    logic          accept;
    logic [3:0]    eff_ch;
    logic [7:0]    mask;
    logic [7:0]    lv;
    logic          ch_ok;
    logic          ch_bit;
    logic          hit;
    logic [29:0]   step;
    logic [AW-1:0] wr_idx_inc;
    logic [31:0]   total_inc;
    logic [31:0]   target_eff;
    logic          done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_ch_reg  <= 4'd8;
            trig_ch_reg    <= 4'd0;
            trig_level_reg <= lcp_pkg::LVL_NONE;
            target_reg     <= 32'd4096;
            ns_per_reg     <= 30'd1000;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lcp_pkg::REG_ACTIVE_CH:  active_ch_reg  <= cfg_wr_data[3:0];
                lcp_pkg::REG_TRIG_CH:    trig_ch_reg    <= cfg_wr_data[3:0];
                lcp_pkg::REG_TRIG_LEVEL: trig_level_reg <= cfg_wr_data[1:0];
                lcp_pkg::REG_TARGET:     target_reg     <= cfg_wr_data;
                lcp_pkg::REG_NS_PER:     ns_per_reg     <= cfg_wr_data[29:0];
                default: ;
            endcase
        end
    end

    // no new beat while a replay reads the history store
    assign s_tready = !q_full && !pending_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (active_ch_reg == 4'd0) begin
            eff_ch = 4'd1;
        end else if (active_ch_reg > 4'd8) begin
            eff_ch = 4'd8;
        end else begin
            eff_ch = active_ch_reg;
        end
    end

    assign mask   = 8'hFF >> (4'd8 - eff_ch);
    assign lv     = s_tdata & mask;
    assign ch_ok  = !trig_ch_reg[3] && (trig_ch_reg < eff_ch);
    assign ch_bit = lv[trig_ch_reg[2:0]];
    assign hit    = ch_ok && (((trig_level_reg == lcp_pkg::LVL_HIGH) && ch_bit) ||
                              ((trig_level_reg == lcp_pkg::LVL_LOW) && !ch_bit));

    always_comb begin
        if (ns_per_reg == 30'd0) begin
            step = 30'd1;
        end else if (ns_per_reg > lcp_pkg::NS_MAX) begin
            step = lcp_pkg::NS_MAX;
        end else begin
            step = ns_per_reg;
        end
    end

    assign wr_idx_inc = (wr_idx_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    assign total_inc  = (total_reg == 32'hFFFF_FFFF) ? total_reg : total_reg + 32'd1;
    assign target_eff = (target_reg == 32'd0) ? 32'd1 : target_reg;
    assign done       = total_inc >= target_eff;

    always_comb begin
        running_next = running_reg;
        trig_next    = trig_reg;
        pending_next = pending_reg;
        wr_idx_next  = wr_idx_reg;
        time_next    = time_reg;
        total_next   = total_reg;
        q_push       = 1'b0;
        q_cmd        = '0;
        hist_wr      = '0;
        hist_wr.levels = lv;
        hist_wr.ts     = time_reg;
        if (accept) begin
            case (s_tuser)
                lcp_pkg::OP_START: begin
                    q_push = 1'b1;
                    if (running_reg) begin
                        q_cmd.kind = lcp_pkg::KIND_START_REF;
                    end else begin
                        q_cmd.kind   = lcp_pkg::KIND_START_OK;
                        running_next = 1'b1;
                        trig_next    = 1'b0;
                        wr_idx_next  = '0;
                        time_next    = '0;
                        total_next   = '0;
                        hist_wr.clr  = 1'b1;
                    end
                end
                lcp_pkg::OP_STOP: begin
                    if (running_reg) begin
                        running_next = 1'b0;
                        q_push       = 1'b1;
                        q_cmd.kind   = lcp_pkg::KIND_STOPPED;
                    end
                end
                lcp_pkg::OP_SAMPLE: begin
                    if (running_reg) begin
                        time_next = time_reg + 64'(step);
                        if (!trig_reg) begin
                            hist_wr.en  = 1'b1;
                            wr_idx_next = wr_idx_inc;
                            if (hit) begin
                                trig_next    = 1'b1;
                                pending_next = 1'b1;
                                total_next   = 32'(HISTORY_DEPTH);
                                q_push       = 1'b1;
                                q_cmd.replay = 1'b1;
                                q_cmd.kind   = lcp_pkg::KIND_TRIG;
                                q_cmd.levels = lv;
                                q_cmd.ts     = time_reg;
                            end
                        end else begin
                            total_next   = total_inc;
                            q_push       = 1'b1;
                            q_cmd.kind   = lcp_pkg::KIND_LIVE;
                            q_cmd.levels = lv;
                            q_cmd.ts     = time_reg;
                            q_cmd.done   = done;
                            if (done) begin
                                running_next = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (replay_done) begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            trig_reg    <= 1'b0;
            pending_reg <= 1'b0;
            wr_idx_reg  <= '0;
            time_reg    <= '0;
            total_reg   <= '0;
        end else begin
            running_reg <= running_next;
            trig_reg    <= trig_next;
            pending_reg <= pending_next;
            wr_idx_reg  <= wr_idx_next;
            time_reg    <= time_next;
            total_reg   <= total_next;
        end
    end

    assign hist_idx = wr_idx_reg;

    `ASSERT_NEVER(a_no_double_replay, q_push && q_cmd.replay && pending_reg,
        "second replay queued while one is pending")
    `ASSERT_NEVER(a_no_hist_write_after_trig, hist_wr.en && trig_reg,
        "history written after trigger")
    `ASSERT_CLK(a_start_clears, hist_wr.clr |=> (total_reg == 32'd0) && running_reg,
        "start did not reset the session")

endmodule

`default_nettype wire

// File: hw/rtl/lcp_queue.sv
// short job queue between front and back end
`default_nettype none

module lcp_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire lcp_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output lcp_pkg::cmd_t      head,
    output logic               empty
);

    lcp_pkg::cmd_t                 q_mem_reg [lcp_pkg::QUEUE_DEPTH];
    logic [lcp_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [lcp_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [lcp_pkg::QPTR_W:0]      count_reg;

    assign full  = count_reg == (lcp_pkg::QPTR_W + 1)'(lcp_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lcp_back.sv
// back end: history store, replay sequencer and output register
`default_nettype none
`include "assert_macros.svh"

module lcp_back #(
    parameter int HISTORY_DEPTH = 32,
    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lcp_pkg::hist_wr_t hist_wr,
    input  wire logic [AW-1:0]     hist_idx,
    input  wire logic              q_empty,
    input  wire lcp_pkg::cmd_t     q_head,
    output logic                   q_pop,
    output logic                   replay_done,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [79:0]            m_tdata,
    output logic [2:0]             m_tuser,
    output logic                   m_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HIST = 2'd1;
    localparam logic [1:0] ST_TRIG = 2'd2;

    logic [71:0]              mem_reg [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [71:0]              rdata_reg;
    logic                     rvld_reg;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [AW-1:0] remain_reg, remain_next;
    logic [7:0]    trig_lv_reg, trig_lv_next;
    logic [63:0]   trig_ts_reg, trig_ts_next;

    logic          out_vld_reg, out_vld_next;
    logic [2:0]    out_kind_reg, out_kind_next;
    logic [7:0]    out_lv_reg, out_lv_next;
    logic [63:0]   out_ts_reg, out_ts_next;
    logic          out_last_reg, out_last_next;
    logic          out_done_reg, out_done_next;

    logic          load_ok;
    logic [AW-1:0] rd_addr_inc;

    // history store, registered read looked up at the next read address
    always_ff @(posedge aclk) begin
        if (hist_wr.en) begin
            mem_reg[hist_idx] <= {hist_wr.levels, hist_wr.ts};
        end
        rdata_reg <= mem_reg[rd_addr_next];
    end

    // entries not written since start read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn || hist_wr.clr) begin
            valid_reg <= '0;
            rvld_reg  <= 1'b0;
        end else begin
            if (hist_wr.en) begin
                valid_reg[hist_idx] <= 1'b1;
            end
            rvld_reg <= valid_reg[rd_addr_next];
        end
    end

    assign load_ok     = !out_vld_reg || m_tready;
    assign rd_addr_inc = (rd_addr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_addr_reg + 1'b1;

    always_comb begin
        state_next    = state_reg;
        rd_addr_next  = rd_addr_reg;
        remain_next   = remain_reg;
        trig_lv_next  = trig_lv_reg;
        trig_ts_next  = trig_ts_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_kind_next = out_kind_reg;
        out_lv_next   = out_lv_reg;
        out_ts_next   = out_ts_reg;
        out_last_next = out_last_reg;
        out_done_next = out_done_reg;
        q_pop         = 1'b0;
        replay_done   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty && load_ok) begin
                    q_pop = 1'b1;
                    if (!q_head.replay || (HISTORY_DEPTH == 1)) begin
                        out_vld_next  = 1'b1;
                        out_kind_next = q_head.kind;
                        out_lv_next   = q_head.levels;
                        out_ts_next   = q_head.ts;
                        out_last_next = 1'b1;
                        out_done_next = q_head.done;
                        replay_done   = q_head.replay;
                    end else begin
                        trig_lv_next = q_head.levels;
                        trig_ts_next = q_head.ts;
                        rd_addr_next = hist_idx;
                        remain_next  = AW'(HISTORY_DEPTH - 1);
                        state_next   = ST_HIST;
                    end
                end
            end
            ST_HIST: begin
                if (load_ok) begin
                    out_vld_next  = 1'b1;
                    out_kind_next = lcp_pkg::KIND_HIST;
                    out_lv_next   = rvld_reg ? rdata_reg[71:64] : 8'd0;
                    out_ts_next   = rvld_reg ? rdata_reg[63:0] : 64'd0;
                    out_last_next = 1'b0;
                    out_done_next = 1'b0;
                    if (remain_reg == AW'(1)) begin
                        state_next = ST_TRIG;
                    end else begin
                        rd_addr_next = rd_addr_inc;
                        remain_next  = remain_reg - 1'b1;
                    end
                end
            end
            ST_TRIG: begin
                if (load_ok) begin
                    out_vld_next  = 1'b1;
                    out_kind_next = lcp_pkg::KIND_TRIG;
                    out_lv_next   = trig_lv_reg;
                    out_ts_next   = trig_ts_reg;
                    out_last_next = 1'b1;
                    out_done_next = 1'b0;
                    replay_done   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            rd_addr_reg <= '0;
            remain_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            rd_addr_reg <= rd_addr_next;
            remain_reg  <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        trig_lv_reg  <= trig_lv_next;
        trig_ts_reg  <= trig_ts_next;
        out_kind_reg <= out_kind_next;
        out_lv_reg   <= out_lv_next;
        out_ts_reg   <= out_ts_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_done_reg, out_ts_reg, out_lv_reg};

    `ASSERT_CLK(a_hist_not_last, (state_reg == ST_HIST) && m_tvalid |-> !m_tlast,
        "last flag on a history beat")
    `ASSERT_CLK(a_remain_nonzero, (state_reg == ST_HIST) |-> (remain_reg != '0),
        "replay running with nothing left")
    `ASSERT_CLK(a_replay_ends_trig,
        replay_done |=> m_tvalid && m_tlast && (m_tuser == lcp_pkg::KIND_TRIG),
        "replay did not end on the trigger sample")

endmodule

`default_nettype wire

// File: hw/rtl/logic_capture_pretrigger.sv
// top level of the logic capture block with level trigger and pre-trigger history
`default_nettype none

// Logic-analyser capture with a single-channel level trigger and a HISTORY_DEPTH-entry
// pre-trigger store. Start, stop and sample beats are taken one per clock while the job
// queue has room and no replay is pending, and each yields at most one result beat but
// the beat that fires the trigger, which yields HISTORY_DEPTH result beats
// (the stored history oldest first, then the trigger sample); while they are read out
// of the history memory, one entry a cycle through its single read port while the result
// side accepts beats, the input is held off. The job is first taken from the queue and
// the first history entry read; the input is released once the trigger sample is loaded
// for output; stalls on the result side and result beats queued ahead hold it longer.
// A four-entry job queue sits between the input side and the result register, so
// either side may stall briefly without holding up the other. The history store is
// emptied at start by clearing per-entry valid bits; there is no clearing pass.
// Result beats: m_tuser is the kind, m_tlast marks the final beat caused by an input
// beat, m_tdata carries levels, timestamp and the capture-done flag.
module logic_capture_pretrigger #(
    parameter int HISTORY_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] raw_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [7:0] levels, [71:8] timestamp, [72] capture_done
    output logic [2:0]       m_tuser,   // [2:0] kind
    output logic             m_tlast
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    lcp_pkg::cmd_t     push_cmd;
    lcp_pkg::cmd_t     head;
    lcp_pkg::hist_wr_t hist_wr;
    logic [AW-1:0]     hist_idx;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic              replay_done;

    lcp_front #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd),
        .hist_wr     (hist_wr),
        .hist_idx    (hist_idx),
        .replay_done (replay_done)
    );

    lcp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty)
    );

    lcp_back #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hist_wr     (hist_wr),
        .hist_idx    (hist_idx),
        .q_empty     (q_empty),
        .q_head      (head),
        .q_pop       (q_pop),
        .replay_done (replay_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire
